FILE: sv/lru_page_replacement_top_defines.svh
// ----------------------------------------------------------------------------
// LRU page replacement - assertion macros
// Shared checking macros for the LRU page tracker; compiled out when
// NO_ASSERTIONS is defined.
// ----------------------------------------------------------------------------
`ifndef LRU_PAGE_REPLACEMENT_TOP_DEFINES_SVH
`define LRU_PAGE_REPLACEMENT_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Check a property on every rising clock edge outside reset.
`define LRUPR_ASSERT(lbl, clk_s, rstn_s, prop_s, msg_s) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) prop_s) else $error(msg_s);
// Check that a condition never holds outside reset.
`define LRUPR_ASSERT_NEVER(lbl, clk_s, rstn_s, expr_s, msg_s) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) !(expr_s)) else $error(msg_s);
`else
`define LRUPR_ASSERT(lbl, clk_s, rstn_s, prop_s, msg_s)
`define LRUPR_ASSERT_NEVER(lbl, clk_s, rstn_s, expr_s, msg_s)
`endif

`endif

FILE: sv/lrupr_pkg.sv
// ----------------------------------------------------------------------------
// LRU page replacement - package
// Sizes, sequencer states and the command/status words between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package lrupr_pkg;

    // built depth of the page store and page number width
    localparam int MAX_SLOTS = 16;
    localparam int PAGE_BITS = 16;

    // slot index and occupancy widths
    localparam int SLOT_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int CNT_W  = $clog2(MAX_SLOTS + 1);

    // capacity register and miss counter
    localparam int CAP_W = 5;
    localparam int CMP_W = (CAP_W > CNT_W) ? CAP_W : CNT_W;
    localparam int MISS_W = 32;
    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

    // configuration port
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;
    localparam int REG_IDX_W = APB_AW - 2;
    localparam logic [REG_IDX_W-1:0] REG_CAPACITY = '0;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_UPDATE
    } lrupr_state_t;

    // controller to datapath
    typedef struct packed {
        logic load;      // capture a new reference
        logic step;      // compare miss: advance the scan
        logic mark_hit;  // compare hit: record the position
        logic commit;    // reorder the store and post the result
    } lrupr_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic empty;     // no resident pages
        logic match;     // scanned entry equals the reference
        logic at_last;   // scan sits on the least recent entry
        logic out_free;  // result register can take a word
    } lrupr_sts_t;

endpackage

FILE: sv/lrupr_ref_if.sv
// ----------------------------------------------------------------------------
// LRU page replacement - reference channel
// Valid/ready channel that carries one page reference per word.
// ----------------------------------------------------------------------------
interface lrupr_ref_if;
    import lrupr_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [PAGE_BITS-1:0] page_number;

    modport source (output valid, output page_number, input ready);
    modport sink   (input valid, input page_number, output ready);

endinterface

FILE: sv/lrupr_res_if.sv
// ----------------------------------------------------------------------------
// LRU page replacement - result channel
// Valid/ready channel that carries one lookup result per word.
// ----------------------------------------------------------------------------
interface lrupr_res_if;
    import lrupr_pkg::*;

    logic                 valid;
    logic                 ready;
    logic                 hit;
    logic                 evict_valid;
    logic [PAGE_BITS-1:0] evicted_page;
    logic [MISS_W-1:0]    miss_total;

    modport source (output valid, output hit, output evict_valid, output evicted_page,
                    output miss_total, input ready);
    modport sink   (input valid, input hit, input evict_valid, input evicted_page,
                    input miss_total, output ready);

endinterface

FILE: sv/lrupr_dpath.sv
// ----------------------------------------------------------------------------
// LRU page replacement - datapath
// Recency shift line, scan pointer, occupancy and miss counters, and the
// result register.
// ----------------------------------------------------------------------------
`include "lru_page_replacement_top_defines.svh"

module lrupr_dpath (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [lrupr_pkg::CAP_W-1:0]  capacity,
    input  logic [lrupr_pkg::PAGE_BITS-1:0] page_number,
    input  lrupr_pkg::lrupr_cmd_t        cmd,
    output lrupr_pkg::lrupr_sts_t        sts,
    lrupr_res_if.source                  res
);
    import lrupr_pkg::*;

    // recency order, entry 0 most recent
    logic [PAGE_BITS-1:0] slot_reg [MAX_SLOTS];

    logic [PAGE_BITS-1:0] page_reg;
    logic [PAGE_BITS-1:0] cand_reg;
    logic [SLOT_W-1:0]    idx_reg;
    logic [SLOT_W-1:0]    pos_reg;
    logic                 found_reg;
    logic [CNT_W-1:0]     occ_reg;
    logic [MISS_W-1:0]    miss_reg;

    logic                 out_valid_reg;
    logic                 out_hit_reg;
    logic                 out_evict_reg;
    logic [PAGE_BITS-1:0] out_page_reg;

    logic [PAGE_BITS-1:0] rd_data;
    logic [CMP_W-1:0]     cap_x;
    logic [CNT_W-1:0]     cap_eff;
    logic                 full;
    logic                 evict_c;
    logic [CNT_W-1:0]     upto;
    logic                 out_free;

    // scan read port
    assign rd_data = slot_reg[idx_reg];

    // clamp the configured capacity into 1..MAX_SLOTS
    always_comb
    begin
        cap_x = CMP_W'(capacity);
        if (cap_x == '0)
        begin
            cap_eff = CNT_W'(1);
        end
        else if (cap_x > CMP_W'(MAX_SLOTS))
        begin
            cap_eff = CNT_W'(MAX_SLOTS);
        end
        else
        begin
            cap_eff = CNT_W'(cap_x);
        end
    end

    // decide the reorder span and the eviction
    assign full    = (occ_reg >= cap_eff);
    assign evict_c = !found_reg && full;

    always_comb
    begin
        if (found_reg)
        begin
            upto = CNT_W'(pos_reg);
        end
        else if (!full)
        begin
            upto = occ_reg;
        end
        else
        begin
            upto = occ_reg - CNT_W'(1);
        end
    end

    assign out_free = !out_valid_reg || res.ready;

    // status to the controller
    assign sts.empty    = (occ_reg == '0);
    assign sts.match    = (rd_data == page_reg);
    assign sts.at_last  = (CNT_W'(idx_reg) == (occ_reg - CNT_W'(1)));
    assign sts.out_free = out_free;

    // capture the reference, walk the scan pointer
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            page_reg <= page_number;
            idx_reg  <= '0;
        end
        else if (cmd.step)
        begin
            cand_reg <= rd_data;
            idx_reg  <= idx_reg + SLOT_W'(1);
        end
        if (cmd.mark_hit)
        begin
            pos_reg <= idx_reg;
        end
    end

    // hit flag for the current reference
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
        end
        else if (cmd.load)
        begin
            found_reg <= 1'b0;
        end
        else if (cmd.mark_hit)
        begin
            found_reg <= 1'b1;
        end
    end

    // shift the span down by one and put the page in front
    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            slot_reg[0] <= page_reg;
            for (int i = 1; i < MAX_SLOTS; i++)
            begin
                if (CNT_W'(i) <= upto)
                begin
                    slot_reg[i] <= slot_reg[i-1];
                end
            end
        end
    end

    // occupancy and saturating miss total
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg  <= '0;
            miss_reg <= '0;
        end
        else if (cmd.commit && !found_reg)
        begin
            if (!full)
            begin
                occ_reg <= occ_reg + CNT_W'(1);
            end
            if (miss_reg != '1)
            begin
                miss_reg <= miss_reg + MISS_W'(1);
            end
        end
    end

    // result register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.commit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (res.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // result register payload
    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            out_hit_reg   <= found_reg;
            out_evict_reg <= evict_c;
            out_page_reg  <= evict_c ? cand_reg : '0;
        end
    end

    assign res.valid        = out_valid_reg;
    assign res.hit          = out_hit_reg;
    assign res.evict_valid  = out_evict_reg;
    assign res.evicted_page = out_page_reg;
    assign res.miss_total   = miss_reg;

    // checks
    `LRUPR_ASSERT_NEVER(a_occ_bound, clk, rst_n, occ_reg > CNT_W'(MAX_SLOTS), "occupancy above depth")
    `LRUPR_ASSERT(a_no_overwrite, clk, rst_n, cmd.commit |-> out_free, "result overwritten")
    `LRUPR_ASSERT(a_evict_keeps_occ, clk, rst_n, cmd.commit && evict_c |=> occ_reg == $past(occ_reg), "eviction changed occupancy")
    `LRUPR_ASSERT(a_hit_keeps_miss, clk, rst_n, cmd.commit && found_reg |=> miss_reg == $past(miss_reg), "hit counted as miss")

endmodule

FILE: sv/lrupr_ctrl.sv
// ----------------------------------------------------------------------------
// LRU page replacement - controller
// Sequencer: take a reference, scan the recency order, then commit the
// reorder and the result.
// ----------------------------------------------------------------------------
`include "lru_page_replacement_top_defines.svh"

module lrupr_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  lrupr_pkg::lrupr_sts_t  sts,
    output lrupr_pkg::lrupr_cmd_t  cmd
);
    import lrupr_pkg::*;

    lrupr_state_t state_reg;
    lrupr_state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = sts.empty ? ST_UPDATE : ST_SEARCH;
                end
            end
            ST_SEARCH:
            begin
                if (sts.match || sts.at_last)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                if (sts.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        in_ready = 1'b0;
        cmd      = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ST_SEARCH:
            begin
                cmd.mark_hit = sts.match;
                cmd.step     = !sts.match;
            end
            ST_UPDATE:
            begin
                cmd.commit = sts.out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    // checks
    `LRUPR_ASSERT_NEVER(a_scan_nonempty, clk, rst_n, state_reg == ST_SEARCH && sts.empty, "scan of empty store")
    `LRUPR_ASSERT(a_commit_returns, clk, rst_n, cmd.commit |=> state_reg == ST_IDLE, "no return after commit")
    `LRUPR_ASSERT(a_update_holds, clk, rst_n, state_reg == ST_UPDATE && !sts.out_free |=> state_reg == ST_UPDATE, "update left while blocked")

endmodule

FILE: sv/lru_page_replacement_top.sv
// ----------------------------------------------------------------------------
// LRU page replacement - top level
// Fully associative LRU page tracker with an APB capacity register.
// ----------------------------------------------------------------------------
// Each page reference returns one result word: hit, eviction flag, the
// evicted page (zero when none) and the saturating miss total. One reference
// is worked on at a time; a scan compares one resident entry per cycle and
// stops at a hit or at the least recent entry, an empty store skips the scan,
// and the commit waits until the output register can take the word. A new
// reference is accepted while the previous result still waits in the output
// register. Capacity sits at byte address 0, resets to 16, and is clamped
// into 1..16; lowering it keeps resident pages and later misses evict.
// Write it only while idle.
// ----------------------------------------------------------------------------
module lru_page_replacement_top (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [lrupr_pkg::APB_AW-1:0] paddr,
    input  logic [lrupr_pkg::APB_DW-1:0] pwdata,
    output logic [lrupr_pkg::APB_DW-1:0] prdata,
    output logic                         pready,
    lrupr_ref_if.sink                    page_ref,
    lrupr_res_if.source                  page_res
);
    import lrupr_pkg::*;

    logic [CAP_W-1:0]     capacity_reg;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 cfg_wr;
    lrupr_cmd_t           cmd;
    lrupr_sts_t           sts;

    // decode the register port
    assign pready  = 1'b1;
    assign reg_idx = paddr[APB_AW-1:2];
    assign cfg_wr  = psel && penable && pwrite && pready && (reg_idx == REG_CAPACITY);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= CAP_RESET;
        end
        else if (cfg_wr)
        begin
            capacity_reg <= pwdata[CAP_W-1:0];
        end
    end

    assign prdata = (reg_idx == REG_CAPACITY) ? {{(APB_DW-CAP_W){1'b0}}, capacity_reg} : '0;

    // sequencer
    lrupr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (page_ref.valid),
        .in_ready (page_ref.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // store, counters and result register
    lrupr_dpath u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .capacity    (capacity_reg),
        .page_number (page_ref.page_number),
        .cmd         (cmd),
        .sts         (sts),
        .res         (page_res)
    );

endmodule

FILE: tb/lrupr_lookup_check.sv
// ----------------------------------------------------------------------------
// LRU page replacement - lookup checker
// Watches the configuration port and both word channels, keeps its own
// recency list of resident pages, predicts the result word of every accepted
// page reference and compares it field by field with the word that comes out.
// ----------------------------------------------------------------------------
module lrupr_lookup_check (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [lrupr_pkg::APB_AW-1:0] paddr,
    input  logic [lrupr_pkg::APB_DW-1:0] pwdata,
    input  logic                         pready,
    lrupr_ref_if                         page_ref,
    lrupr_res_if                         page_res,
    output int unsigned                  mismatch_count,
    output int unsigned                  pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    import lrupr_pkg::*;

    localparam int unsigned REPORT_LIMIT = 50;

    typedef struct packed {
        logic                 hit;
        logic                 evict_valid;
        logic [PAGE_BITS-1:0] evicted_page;
        logic [MISS_W-1:0]    miss_total;
    } lookup_word_t;

    // predicted store: entry 0 is the most recently used page
    logic [PAGE_BITS-1:0] lru_list [MAX_SLOTS];
    int unsigned          resident;
    logic [MISS_W-1:0]    misses;
    logic [CAP_W-1:0]     capacity_q;

    lookup_word_t         expected_words [$];
    lookup_word_t         want;
    int unsigned          errors;

    // move entries [0, upto) one place older and put the page in front
    function automatic void promote_page(input int unsigned upto, input logic [PAGE_BITS-1:0] page);
        for (int unsigned i = upto; i > 0; i--)
            lru_list[i] = lru_list[i-1];
        lru_list[0] = page;
    endfunction

    // look the page up, update the recency list and build the result word
    function automatic lookup_word_t reference_page(input logic [PAGE_BITS-1:0] page);
        lookup_word_t w;
        int unsigned  slots;
        int unsigned  pos;
        bit           found;
        w     = '0;
        found = 1'b0;
        pos   = 0;
        slots = capacity_q;
        if (slots < 1)
            slots = 1;
        if (slots > MAX_SLOTS)
            slots = MAX_SLOTS;
        for (int unsigned i = 0; i < resident; i++)
        begin
            if (!found && lru_list[i] == page)
            begin
                found = 1'b1;
                pos   = i;
            end
        end
        if (found)
        begin
            w.hit = 1'b1;
            promote_page(pos, page);
        end
        else
        begin
            if (misses != '1)
                misses++;
            if (resident < slots)
            begin
                promote_page(resident, page);
                resident++;
            end
            else
            begin
                // full (or capacity lowered below occupancy): drop the oldest page
                w.evict_valid  = 1'b1;
                w.evicted_page = lru_list[resident-1];
                promote_page(resident - 1, page);
            end
        end
        w.miss_total = misses;
        return w;
    endfunction

    function automatic void check_field(input string field, input logic [31:0] exp_val,
                                        input logic [31:0] got_val);
        if (exp_val !== got_val)
        begin
            errors++;
            if (errors <= REPORT_LIMIT)
                $display("%0t: %s mismatch, expected %0h, got %0h",
                         $time, field, exp_val, got_val);
        end
    endfunction

    // track config writes, predict on accepted references, compare on results
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            resident   = 0;
            misses     = '0;
            capacity_q = CAP_RESET;
            errors     = 0;
            expected_words.delete();
            mismatch_count <= 0;
            pending_count  <= 0;
        end
        else
        begin
            if (page_res.valid && page_res.ready)
            begin
                if (expected_words.size() == 0)
                begin
                    errors++;
                    if (errors <= REPORT_LIMIT)
                        $display("%0t: result word with none expected, got hit %0b evict %0b page %0h misses %0h",
                                 $time, page_res.hit, page_res.evict_valid,
                                 page_res.evicted_page, page_res.miss_total);
                end
                else
                begin
                    want = expected_words.pop_front();
                    check_field("hit", 32'(want.hit), 32'(page_res.hit));
                    check_field("evict_valid", 32'(want.evict_valid), 32'(page_res.evict_valid));
                    check_field("evicted_page", 32'(want.evicted_page), 32'(page_res.evicted_page));
                    check_field("miss_total", 32'(want.miss_total), 32'(page_res.miss_total));
                end
            end
            if (page_ref.valid && page_ref.ready)
                expected_words.push_back(reference_page(page_ref.page_number));
            // writes to any index but the capacity register are dropped
            if (psel && penable && pwrite && pready && paddr[APB_AW-1:2] == REG_CAPACITY)
                capacity_q = pwdata[CAP_W-1:0];
            mismatch_count <= errors;
            pending_count  <= expected_words.size();
        end
    end

endmodule

FILE: tb/tb_lru_page_replacement_top.sv
// ----------------------------------------------------------------------------
// LRU page replacement - testbench top
// Drives page references and capacity writes into the tracker: a directed
// pass over fill, hits at depth, eviction and capacity clamping, then random
// phases over several capacities with sender gaps and receiver stalls. The
// lookup checker predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_lru_page_replacement_top;
    timeunit 1ns;
    timeprecision 1ps;

    import lrupr_pkg::*;

    localparam int          NUM_PHASES     = 8;
    localparam int          PHASE_WORDS    = 225;
    localparam int          DRAIN_CYCLES   = 40;
    localparam int unsigned WATCHDOG_LIMIT = 4000;

    localparam logic [APB_AW-1:0] CAP_ADDR   = APB_AW'({REG_CAPACITY, 2'b00});
    localparam logic [APB_AW-1:0] UNUSED_ADDR = APB_AW'(4);

    logic              clk = 1'b0;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    int unsigned       mismatch_count;
    int unsigned       pending_count;
    int unsigned       quiet_cycles;
    int unsigned       sender_idle_pct;
    int unsigned       receiver_stall_pct;

    logic [CAP_W-1:0]  phase_caps [NUM_PHASES] =
        '{5'd1, 5'd16, 5'd0, 5'd31, 5'd5, 5'd17, 5'd2, 5'd9};

    lrupr_ref_if page_ref ();
    lrupr_res_if page_res ();

    lru_page_replacement_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .page_ref (page_ref),
        .page_res (page_res)
    );

    lrupr_lookup_check u_lookup_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .pready         (pready),
        .page_ref       (page_ref),
        .page_res       (page_res),
        .mismatch_count (mismatch_count),
        .pending_count  (pending_count)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // result side: stall at random per the current phase
    always @(negedge clk)
        page_res.ready = ($urandom_range(0, 99) >= receiver_stall_pct);

    // abort when nothing moves for too long
    always @(posedge clk)
    begin
        if (!rst_n)
            quiet_cycles <= 0;
        else if ((page_ref.valid && page_ref.ready) || (page_res.valid && page_res.ready) ||
                 (psel && penable && pready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("[lru_page_replacement_top] ERROR");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // offer one page reference and hold it until the block takes it
    task automatic send_page(input logic [PAGE_BITS-1:0] page);
        @(negedge clk);
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            page_ref.valid = 1'b0;
            @(negedge clk);
        end
        page_ref.valid       = 1'b1;
        page_ref.page_number = page;
        do
            @(posedge clk);
        while (!page_ref.ready);
    endtask

    // drop valid, wait for every result word, then write one register
    task automatic write_capacity(input logic [APB_AW-1:0] addr, input logic [CAP_W-1:0] cap);
        logic [APB_DW-1:0] wdata;
        wdata            = $urandom();
        wdata[CAP_W-1:0] = cap;
        @(negedge clk);
        page_ref.valid = 1'b0;
        while (pending_count != 0)
            @(posedge clk);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = addr;
        pwdata  = wdata;
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (!pready);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    initial
    begin
        int unsigned          slots;
        int unsigned          span;
        logic [CAP_W-1:0]     cap;
        logic [PAGE_BITS-1:0] base;
        logic [PAGE_BITS-1:0] page;

        rst_n                = 1'b0;
        psel                 = 1'b0;
        penable              = 1'b0;
        pwrite               = 1'b0;
        paddr                = '0;
        pwdata               = '0;
        page_ref.valid       = 1'b0;
        page_ref.page_number = '0;
        page_res.ready       = 1'b0;
        sender_idle_pct      = 0;
        receiver_stall_pct   = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset capacity: extremes of the page field, hits at depth
        send_page(16'h0000);
        send_page(16'hFFFF);
        send_page(16'h0000);
        send_page(16'hFFFF);
        send_page(16'h8001);
        send_page(16'h7FFE);
        send_page(16'h0000);

        // capacity zero acts as one; deeper pages stay resident until evicted
        write_capacity(CAP_ADDR, 5'd0);
        send_page(16'hFFFF);
        send_page(16'h1234);
        send_page(16'h1234);
        send_page(16'hABCD);

        // oversized capacity clamps to the full depth; spare index is ignored
        write_capacity(CAP_ADDR, 5'd31);
        write_capacity(UNUSED_ADDR, 5'd1);
        for (int i = 0; i < 12; i++)
            send_page(PAGE_BITS'(16'h0100 + i));
        send_page(16'h0200);

        // random phases: working set around the capacity plus wide noise
        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            cap = phase_caps[ph];
            if (ph == NUM_PHASES - 1)
                cap = CAP_W'($urandom_range(0, 31));
            write_capacity(CAP_ADDR, cap);
            case (ph % 4)
                0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
                1: begin sender_idle_pct = 84; receiver_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  receiver_stall_pct = 84; end
                default: begin sender_idle_pct = 12; receiver_stall_pct = 12; end
            endcase
            slots = (cap == 0) ? 1 : ((cap > MAX_SLOTS) ? MAX_SLOTS : cap);
            span  = slots + 3;
            base  = PAGE_BITS'($urandom());
            repeat (PHASE_WORDS)
            begin
                if ($urandom_range(0, 99) < 80)
                    page = base + PAGE_BITS'($urandom_range(0, span));
                else
                    page = PAGE_BITS'($urandom());
                send_page(page);
            end
        end

        // drain and settle
        @(negedge clk);
        page_ref.valid = 1'b0;
        while (pending_count != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && pending_count == 0)
            $display("[lru_page_replacement_top] OK");
        else
            $display("[lru_page_replacement_top] ERROR");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+sv
sv/lrupr_pkg.sv
sv/lrupr_ref_if.sv
sv/lrupr_res_if.sv
sv/lrupr_dpath.sv
sv/lrupr_ctrl.sv
sv/lru_page_replacement_top.sv
tb/lrupr_lookup_check.sv
tb/tb_lru_page_replacement_top.sv
